>>> src/sha_pkg.sv
package sha_pkg;

    localparam int DIGEST_WORDS = 8;

    typedef logic [31:0] word_t;

    function automatic word_t round_const(input logic [5:0] idx);
        word_t k;
        unique case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t initial_hash(input logic [2:0] idx);
        word_t h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> src/sha_round.sv
module sha_round
    import sha_pkg::*;
(
    input  word_t       a, b, c, e, f, g, h,
    input  word_t       w,
    input  logic [5:0]  rnd,
    output word_t       t1_out,
    output word_t       t2_out
);
    word_t big1, big0, ch, maj;

    always_comb
    begin
        big1   = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch     = (e & f) ^ (~e & g);
        big0   = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        maj    = (a & b) ^ (a & c) ^ (b & c);
        t1_out = h + big1 + ch + round_const(rnd) + w;
        t2_out = big0 + maj;
    end
endmodule

>>> src/sha256_byte_stream_digest.sv
// Input: a data byte is taken while in_stall is low; every 64th byte stalls the input
// while the block loads the working variables, runs the rounds and folds the result.
// After the transfer that ends a message, padding goes in at one byte per cycle in ST_PAD;
// closed blocks are compressed; eight digest words follow, one per cycle unless stalled.
// Reset is asynchronous: control state, counters and the chaining value go to their
// initial values; the schedule memory holds stale words until each is written.
module sha256_byte_stream_digest
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  digest_index,
    output logic [31:0] digest_word,
    output logic        last_word
);
    // Top level states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_RND   = 3'd4;
    localparam logic [2:0] ST_FOLD  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  pos_reg;
    logic [60:0] total_reg;
    logic [6:0]  rnd_reg;
    logic [1:0]  sub_reg;
    logic        end_reg;       // the message has ended; padding follows
    logic        fin_reg;       // the 0x80 marker byte has gone in
    logic [3:0]  len_idx_reg;   // length bytes written so far, 8 when all are in
    logic [2:0]  oidx_reg;
    word_t       chain_reg [DIGEST_WORDS];
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;

    // The schedule window is a 16-entry memory with a registered read port.
    // Each round reads four words, one per cycle, and from round 16 sums them into an
    // accumulator so that the round itself sees a single add ahead of it.
    word_t       sched_mem [16];
    word_t       rd_data_reg;
    logic [3:0]  rd_addr;
    word_t       wacc_reg;
    word_t       s0, s1;

    // A byte-lane register assembles each big-endian word, which is written
    // into the memory whole when its fourth byte arrives.
    word_t       asm_reg;

    logic        accept;
    logic        put_en;
    logic [7:0]  put_byte;
    word_t       t1, t2, w_now;
    logic [63:0] bit_len;
    logic [5:0]  len_sh;
    logic        len_phase;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign bit_len   = {total_reg, 3'b000};
    // Length bytes go most significant first.
    assign len_sh    = {~len_idx_reg[2:0], 3'b000};
    // The length field starts at byte 56 of a block and, once started, runs to its end.
    assign len_phase = (len_idx_reg != 4'd0) || (pos_reg == 6'd56);

    // Byte source: an accepted message byte, or padding generated internally.
    always_comb
    begin
        put_en   = 1'b0;
        put_byte = 8'h00;
        if (state_reg == ST_IDLE && accept && byte_present)
        begin
            put_en   = 1'b1;
            put_byte = data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            put_en = 1'b1;
            if (!fin_reg)
                put_byte = 8'h80;
            else if (len_phase)
                put_byte = bit_len[len_sh +: 8];
            else
                put_byte = 8'h00;
        end
    end

    assign s0 = rotr(rd_data_reg, 7) ^ rotr(rd_data_reg, 18) ^ (rd_data_reg >> 3);
    assign s1 = rotr(rd_data_reg, 17) ^ rotr(rd_data_reg, 19) ^ (rd_data_reg >> 10);

    // Micro-steps in ST_RND (sub 0..3), after ST_RD has launched the read of slot t mod 16:
    //   0: capture word t (word t-16 from round 16), launch the read of word t-15
    //   1: add s0 of word t-15 (from round 16), launch the read of word t-2
    //   2: add s1 of word t-2 (from round 16), launch the read of word t-7
    //   3: word t-7 is on the read data: finish the schedule word, perform the
    //      round, write back from round 16, and launch the read of the next round's slot.
    always_comb
    begin
        w_now = (rnd_reg < 7'd16) ? wacc_reg : (wacc_reg + rd_data_reg);
        if (state_reg != ST_RND)
            rd_addr = rnd_reg[3:0];
        else
        begin
            unique case (sub_reg)
                2'd0: rd_addr = rnd_reg[3:0] + 4'd1;
                2'd1: rd_addr = rnd_reg[3:0] + 4'd14;
                2'd2: rd_addr = rnd_reg[3:0] + 4'd9;
                default: rd_addr = rnd_reg[3:0] + 4'd1;
            endcase
        end
    end

    sha_round u_round (
        .a(a_reg), .b(b_reg), .c(c_reg),
        .e(e_reg), .f(f_reg), .g(g_reg), .h(h_reg),
        .w(w_now), .rnd(rnd_reg[5:0]),
        .t1_out(t1), .t2_out(t2)
    );

    // Memory: one write port, one registered read port. Byte gathering and compression
    // never overlap; during rounds no read targets the word written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (put_en && pos_reg[1:0] == 2'd3)
            sched_mem[pos_reg[5:2]] <= {asm_reg[31:8], put_byte};
        else if (state_reg == ST_RND && sub_reg == 2'd3 && rnd_reg >= 7'd16)
            sched_mem[rnd_reg[3:0]] <= w_now;
        rd_data_reg <= sched_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (put_en)
            asm_reg[{~pos_reg[1:0], 3'b000} +: 8] <= put_byte;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (byte_present && pos_reg == 6'd63)
                        state_next = ST_LOAD;
                    else if (last_byte)
                        state_next = ST_PAD;
                end
            ST_PAD:
                if (pos_reg == 6'd63)
                    state_next = ST_LOAD;
            ST_LOAD: state_next = ST_RD;
            ST_RD:   state_next = ST_RND;
            ST_RND:
                if (sub_reg == 2'd3 && rnd_reg == 7'd63)
                    state_next = ST_FOLD;
            ST_FOLD:
                if (end_reg && len_idx_reg[3])
                    state_next = ST_OUT;
                else if (end_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            ST_OUT:
                if (!out_stall && oidx_reg == 3'd7)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            total_reg   <= '0;
            rnd_reg     <= '0;
            sub_reg     <= '0;
            end_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            len_idx_reg <= '0;
            oidx_reg    <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_reg[i] <= initial_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (put_en)
                pos_reg <= pos_reg + 6'd1;
            if (state_reg == ST_IDLE && accept)
            begin
                if (byte_present)
                    total_reg <= total_reg + 61'd1;
                if (last_byte)
                    end_reg <= 1'b1;
            end
            if (state_reg == ST_PAD)
            begin
                if (!fin_reg)
                    fin_reg <= 1'b1;
                else if (len_phase)
                    len_idx_reg <= len_idx_reg + 4'd1;
            end
            if (state_reg == ST_LOAD)
            begin
                rnd_reg <= '0;
                sub_reg <= '0;
            end
            if (state_reg == ST_RND)
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                    rnd_reg <= rnd_reg + 7'd1;
            end
            if (state_reg == ST_FOLD)
            begin
                rnd_reg <= '0;
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
                chain_reg[5] <= chain_reg[5] + f_reg;
                chain_reg[6] <= chain_reg[6] + g_reg;
                chain_reg[7] <= chain_reg[7] + h_reg;
            end
            if (state_reg == ST_OUT && !out_stall)
            begin
                oidx_reg <= oidx_reg + 3'd1;
                if (oidx_reg == 3'd7)
                begin
                    total_reg   <= '0;
                    pos_reg     <= '0;
                    end_reg     <= 1'b0;
                    fin_reg     <= 1'b0;
                    len_idx_reg <= '0;
                    for (int i = 0; i < DIGEST_WORDS; i++)
                        chain_reg[i] <= initial_hash(3'(i));
                end
            end
        end
    end

    // Working variables and the schedule accumulator.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            a_reg <= chain_reg[0]; b_reg <= chain_reg[1];
            c_reg <= chain_reg[2]; d_reg <= chain_reg[3];
            e_reg <= chain_reg[4]; f_reg <= chain_reg[5];
            g_reg <= chain_reg[6]; h_reg <= chain_reg[7];
        end
        if (state_reg == ST_RND)
        begin
            unique case (sub_reg)
                2'd0: wacc_reg <= rd_data_reg;
                2'd1:
                    if (rnd_reg >= 7'd16)
                        wacc_reg <= wacc_reg + s0;
                2'd2:
                    if (rnd_reg >= 7'd16)
                        wacc_reg <= wacc_reg + s1;
                default:
                begin
                    h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg;
                    e_reg <= d_reg + t1;
                    d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg;
                    a_reg <= t1 + t2;
                end
            endcase
        end
    end

    assign out_valid    = (state_reg == ST_OUT);
    assign digest_index = oidx_reg;
    assign digest_word  = chain_reg[oidx_reg];
    assign last_word    = (oidx_reg == 3'd7);

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept) else $error("transfer taken while busy");
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_word) |-> (digest_index == 3'd7)) else $error("last word index");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(digest_index)))
        else $error("output not held");
`endif
endmodule
